// ----- hdl/cmld_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmld_pkg
// shared widths, register codes and the front-to-back transaction type
// ----------------------------------------------------------------------------
package cmld_pkg;
	localparam int COORD_BITS = 16;
	localparam int MAX_CHAIN  = 4096;
	localparam int DIST_BITS  = 27;
	localparam int IDX_BITS   = 12;
	localparam int CNT_BITS   = $clog2(MAX_CHAIN);
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int CROSS_BITS = 2 * DIFF_BITS + 1;
	localparam int NUM_BITS   = 2 * (CROSS_BITS + 8);
	localparam int LEN_BITS   = 2 * DIFF_BITS + 1;
	localparam int QUO_BITS   = NUM_BITS;
	localparam int ROOT_BITS  = QUO_BITS / 2;
	localparam int QCAP_BITS  = 2 * (DIST_BITS - 1) + 2;
	localparam logic [DIST_BITS-2:0] DIST_CAP = '1;
	localparam logic [1:0] REG_START_X = 2'd0;
	localparam logic [1:0] REG_START_Y = 2'd1;
	localparam logic [1:0] REG_END_X   = 2'd2;
	localparam logic [1:0] REG_END_Y   = 2'd3;

	typedef struct packed {
		logic signed [DIST_BITS-1:0] distance;
		logic                        last;
	} dist_item_t;
endpackage
`default_nettype wire

// ----- hdl/cmld_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmld_front
// distance unit: cross product, long division by |v|^2, then integer root
// ----------------------------------------------------------------------------
module cmld_front (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire signed [cmld_pkg::COORD_BITS-1:0] qx,
	input  wire signed [cmld_pkg::COORD_BITS-1:0] qy,
	input  wire                                  in_last,
	input  wire signed [cmld_pkg::COORD_BITS-1:0] px,
	input  wire signed [cmld_pkg::COORD_BITS-1:0] py,
	input  wire signed [cmld_pkg::COORD_BITS-1:0] ex,
	input  wire signed [cmld_pkg::COORD_BITS-1:0] ey,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output cmld_pkg::dist_item_t                 out_item
);
	import cmld_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SQ   = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_ROOT = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;
	localparam logic [2:0] ST_ACC  = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;
	localparam int DCNT_BITS = $clog2(QUO_BITS);
	localparam int RCNT_BITS = $clog2(ROOT_BITS);
	localparam int MAGH_BITS = (CROSS_BITS - 1) / 2;
	localparam int PP_BITS   = 2 * MAGH_BITS;

	logic [2:0] state_q;
	logic signed [DIFF_BITS-1:0] dx_q, dy_q, vx_q, vy_q;
	logic signed [CROSS_BITS-1:0] cross_q;
	logic [LEN_BITS-1:0] len_q;
	logic neg_q, last_q;
	logic [PP_BITS-1:0] pp_hh_q, pp_hl_q, pp_ll_q;
	logic [NUM_BITS-1:0] num_q;
	logic [LEN_BITS:0] rem_q;
	logic [DCNT_BITS-1:0] dcnt_q;
	logic [RCNT_BITS-1:0] rcnt_q;
	logic [QUO_BITS-1:0] quo_q;
	logic [ROOT_BITS+1:0] rrem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic signed [DIST_BITS-1:0] dist_q;

	logic [CROSS_BITS-1:0] mag_c;
	logic [MAGH_BITS-1:0] mh_c, ml_c;
	logic [LEN_BITS:0] trial_c;
	logic [ROOT_BITS+1:0] rtrial_c, rsub_c;
	logic [DIST_BITS-2:0] k_c;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_item.distance = dist_q;
	assign out_item.last = last_q;

	always_comb begin
		mag_c = cross_q[CROSS_BITS-1] ? CROSS_BITS'(-cross_q) : CROSS_BITS'(cross_q);
		mh_c = mag_c[PP_BITS-1:MAGH_BITS];
		ml_c = mag_c[MAGH_BITS-1:0];
		trial_c = {rem_q[LEN_BITS-1:0], num_q[NUM_BITS-1]};
		rtrial_c = {rrem_q[ROOT_BITS-1:0], quo_q[QUO_BITS-1 -: 2]};
		rsub_c = {root_q, 2'b01};
		k_c = (quo_q[QUO_BITS-1:QCAP_BITS] != '0 || root_q > ROOT_BITS'(DIST_CAP))
			? DIST_CAP : root_q[DIST_BITS-2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						dx_q <= DIFF_BITS'(qx) - DIFF_BITS'(px);
						dy_q <= DIFF_BITS'(qy) - DIFF_BITS'(py);
						vx_q <= DIFF_BITS'(ex) - DIFF_BITS'(px);
						vy_q <= DIFF_BITS'(ey) - DIFF_BITS'(py);
						last_q <= in_last;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					len_q <= LEN_BITS'(vx_q * vx_q) + LEN_BITS'(vy_q * vy_q);
					cross_q <= CROSS_BITS'(dy_q * vx_q) - CROSS_BITS'(dx_q * vy_q);
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					if (len_q == '0) begin
						pp_hh_q <= '0;
						pp_hl_q <= '0;
						pp_ll_q <= PP_BITS'(dx_q * dx_q) + PP_BITS'(dy_q * dy_q);
						len_q <= LEN_BITS'(1);
						neg_q <= 1'b0;
					end else begin
						pp_hh_q <= PP_BITS'(mh_c) * PP_BITS'(mh_c);
						pp_hl_q <= PP_BITS'(mh_c) * PP_BITS'(ml_c);
						pp_ll_q <= PP_BITS'(ml_c) * PP_BITS'(ml_c);
						neg_q <= cross_q[CROSS_BITS-1];
					end
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					// squared magnitude from its partial products, times 2^16
					num_q <= (NUM_BITS'(pp_hh_q) << (2 * MAGH_BITS + 16))
						+ (NUM_BITS'(pp_hl_q) << (MAGH_BITS + 17))
						+ (NUM_BITS'(pp_ll_q) << 16);
					rem_q <= '0;
					dcnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					num_q <= {num_q[NUM_BITS-2:0], 1'b0};
					if (trial_c >= {1'b0, len_q}) begin
						rem_q <= trial_c - {1'b0, len_q};
						quo_q <= {quo_q[QUO_BITS-2:0], 1'b1};
					end else begin
						rem_q <= trial_c;
						quo_q <= {quo_q[QUO_BITS-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCNT_BITS'(QUO_BITS - 1)) begin
						rrem_q <= '0;
						root_q <= '0;
						rcnt_q <= '0;
						num_q <= '0;
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					quo_q <= {quo_q[QUO_BITS-3:0], quo_q[QUO_BITS-1 -: 2]};
					if (rtrial_c >= rsub_c) begin
						rrem_q <= rtrial_c - rsub_c;
						root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
					end else begin
						rrem_q <= rtrial_c;
						root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
					end
					rcnt_q <= rcnt_q + 1'b1;
					if (rcnt_q == RCNT_BITS'(ROOT_BITS - 1)) state_q <= ST_FIN;
				end
				ST_FIN: begin
					dist_q <= neg_q ? -DIST_BITS'({1'b0, k_c}) : DIST_BITS'({1'b0, k_c});
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hdl/cmld_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmld_queue
// two-entry queue between the distance unit and the maximum tracker
// ----------------------------------------------------------------------------
module cmld_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  cmld_pkg::dist_item_t in_item,
	output logic                 out_valid,
	input  wire                  out_ready,
	output cmld_pkg::dist_item_t out_item
);
	import cmld_pkg::*;

	dist_item_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ----- hdl/cmld_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmld_back
// running maximum, vertex numbering and result register
// ----------------------------------------------------------------------------
module cmld_back (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  cmld_pkg::dist_item_t              in_item,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [cmld_pkg::DIST_BITS-1:0]    distance,
	output logic [cmld_pkg::IDX_BITS-1:0]     vertex_index,
	output logic                              chain_done,
	output logic [cmld_pkg::IDX_BITS-1:0]     max_index,
	output logic [cmld_pkg::DIST_BITS-1:0]    max_distance
);
	import cmld_pkg::*;

	logic signed [DIST_BITS-1:0] best_distance_q;
	logic [CNT_BITS-1:0] best_index_q, vertex_count_q;
	logic have_best_q, valid_q;
	logic take, upd;
	logic signed [DIST_BITS-1:0] nb_dist;
	logic [CNT_BITS-1:0] nb_idx;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign take = in_valid && in_ready;
	assign upd = !have_best_q || (in_item.distance > best_distance_q);
	assign nb_dist = upd ? in_item.distance : best_distance_q;
	assign nb_idx  = upd ? vertex_count_q : best_index_q;

	always_ff @(posedge clk) begin
		if (take) begin
			distance <= in_item.distance;
			vertex_index <= IDX_BITS'(vertex_count_q);
			chain_done <= in_item.last;
			max_index <= in_item.last ? IDX_BITS'(nb_idx) : '0;
			max_distance <= in_item.last ? nb_dist : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			best_distance_q <= '0;
			best_index_q <= '0;
			vertex_count_q <= '0;
			have_best_q <= 1'b0;
		end else begin
			if (take) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
			if (take) begin
				if (in_item.last) begin
					best_distance_q <= '0;
					best_index_q <= '0;
					vertex_count_q <= '0;
					have_best_q <= 1'b0;
				end else begin
					best_distance_q <= nb_dist;
					best_index_q <= nb_idx;
					have_best_q <= 1'b1;
					if (vertex_count_q != CNT_BITS'(MAX_CHAIN - 1))
						vertex_count_q <= vertex_count_q + 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- hdl/chain_max_line_distance.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chain_max_line_distance
// signed vertex distance to the endpoint chord with running maximum
// ----------------------------------------------------------------------------
// One vertex is worked on at a time in the distance unit, which takes a vertex only
// when idle: set-up steps (differences, products, squared numerator), a restoring
// division of one quotient bit per cycle over the 86-bit squared numerator, a square
// root of one result bit per cycle, a step for sign and saturation, and a hand-over
// state that waits until the result is taken before the unit is idle again. A two-entry
// queue and an output register hold up to three results before a stalled receiver
// holds up the distance unit.
module chain_max_line_distance (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // vertex_x, vertex_y
	input  wire         s_tlast,   // last_vertex
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [79:0] m_tdata,   // distance, vertex_index, max_index, max_distance, zero fill
	output logic        m_tlast,   // chain_done
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cmld_pkg::*;

	logic signed [COORD_BITS-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic fv, fr, bv, br;
	dist_item_t fi, bi;
	logic [DIST_BITS-1:0] distance, max_distance;
	logic [IDX_BITS-1:0] vertex_index, max_index;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q <= '0;
			end_y_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_START_X: start_x_q <= pwdata[COORD_BITS-1:0];
				REG_START_Y: start_y_q <= pwdata[COORD_BITS-1:0];
				REG_END_X:   end_x_q <= pwdata[COORD_BITS-1:0];
				REG_END_Y:   end_y_q <= pwdata[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_START_X: prdata = 32'(start_x_q);
			REG_START_Y: prdata = 32'(start_y_q);
			REG_END_X:   prdata = 32'(end_x_q);
			REG_END_Y:   prdata = 32'(end_y_q);
			default:     prdata = '0;
		endcase
	end

	cmld_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.qx(s_tdata[15:0]), .qy(s_tdata[31:16]), .in_last(s_tlast),
		.px(start_x_q), .py(start_y_q), .ex(end_x_q), .ey(end_y_q),
		.out_valid(fv), .out_ready(fr), .out_item(fi)
	);

	cmld_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(fv), .in_ready(fr), .in_item(fi),
		.out_valid(bv), .out_ready(br), .out_item(bi)
	);

	cmld_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(bv), .in_ready(br), .in_item(bi),
		.out_valid(m_tvalid), .out_ready(m_tready), .distance(distance),
		.vertex_index(vertex_index), .chain_done(m_tlast), .max_index(max_index),
		.max_distance(max_distance)
	);

	assign m_tdata = {2'b00, max_distance, max_index, vertex_index, distance};

`ifndef SYNTHESIS
	a_max_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (max_index == '0 && max_distance == '0))
		else $error("max fields set before end of chain");
	a_max_ge: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> ($signed(max_distance) >= $signed(distance)))
		else $error("maximum below last distance");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire
